/* hw/rtl/tnp_pkg.sv */
// shared types and telnet constants for the telnet command parser
`timescale 1ns / 1ps
package tnp_pkg;

    // telnet command bytes
    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_SB   = 8'd250;
    localparam logic [7:0] TN_NOP  = 8'd241;

    // option codes
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_WINDOW = 8'd31;

    // subnegotiation bytes needed for a window size report
    localparam logic [2:0] NEED_BYTES = 3'd4;

    // result event kinds
    localparam logic [1:0] EV_DATA  = 2'd0;
    localparam logic [1:0] EV_TX    = 2'd1;
    localparam logic [1:0] EV_ECHO  = 2'd2;
    localparam logic [1:0] EV_WSIZE = 2'd3;

    // actions queued between the parser and the result expander
    typedef enum logic [2:0] {
        ACT_DATA  = 3'd0,
        ACT_NOP   = 3'd1,
        ACT_DONT  = 3'd2,
        ACT_ECHO  = 3'd3,
        ACT_WSIZE = 3'd4
    } t_act;

    typedef struct packed {
        t_act        act;
        logic [7:0]  value;
        logic [15:0] width;
        logic [15:0] height;
    } t_action;

endpackage

/* hw/rtl/telnet_command_parser_top.sv */
// top level of the telnet command parser
`timescale 1ns / 1ps
// Telnet command parser. Received bytes are taken one per clock while full is low; the
// parser decodes IAC commands and queues at most one action per byte in a queue of
// QUEUE_DEPTH entries, and the expander turns the oldest action into its results, one
// result per clock while pop is held. A data byte gives one result, an IAC NOP reply
// two and an IAC WONT reply three; the first result of a request taken into an empty
// queue shows on the result ports the cycle after. Sustained input rate is one byte per
// cycle as long as results are taken at the rate they are made; the queue depth sets
// how long the result side may stall before full rises.
module telnet_command_parser_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_byte_value,
    output logic [15:0] o_window_width,
    output logic [15:0] o_window_height,
    output logic        o_last
);
    import tnp_pkg::*;

    logic    accept;
    logic    act_valid;
    t_action action;
    logic    q_full;
    logic    q_empty;
    t_action head;
    logic    deq;

    assign accept = push && !q_full;
    assign full   = q_full;

    tnp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_act_valid (act_valid),
        .o_action    (action)
    );

    tnp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (act_valid),
        .i_action (action),
        .i_pop    (deq),
        .o_full   (q_full),
        .o_empty  (q_empty),
        .o_head   (head)
    );

    tnp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (!q_empty),
        .i_head          (head),
        .i_pop           (pop),
        .o_deq           (deq),
        .o_empty         (empty),
        .o_event_kind    (o_event_kind),
        .o_byte_value    (o_byte_value),
        .o_window_width  (o_window_width),
        .o_window_height (o_window_height),
        .o_last          (o_last)
    );

endmodule

/* hw/rtl/tnp_front.sv */
// byte parser: walks the telnet command grammar and emits one action per byte at most
`timescale 1ns / 1ps
module tnp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output logic             o_act_valid,
    output tnp_pkg::t_action o_action
);
    import tnp_pkg::*;

    typedef enum logic [6:0] {
        ST_DATA    = 7'b0000001,
        ST_CMD     = 7'b0000010,
        ST_NEGO    = 7'b0000100,
        ST_SBOPT   = 7'b0001000,
        ST_SBFIRST = 7'b0010000,
        ST_SBDATA  = 7'b0100000,
        ST_SBEND   = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_verb, n_verb;
    logic        r_win, n_win;
    logic [2:0]  r_count, n_count;
    logic [31:0] r_bytes, n_bytes;

    logic        keep_ok;
    logic [2:0]  kept_count;
    logic [31:0] kept_bytes;

    // first four subnegotiation data bytes are kept, first one highest
    assign keep_ok    = (r_count < NEED_BYTES);
    assign kept_count = keep_ok ? (r_count + 3'd1) : r_count;
    assign kept_bytes = keep_ok ? {r_bytes[23:0], i_rx_byte} : r_bytes;

    always_comb begin
        n_state     = r_state;
        n_verb      = r_verb;
        n_win       = r_win;
        n_count     = r_count;
        n_bytes     = r_bytes;
        o_act_valid = 1'b0;
        o_action    = '{act: ACT_DATA, value: i_rx_byte, width: 16'd0, height: 16'd0};
        if (i_accept) begin
            unique case (r_state)
                ST_CMD: begin
                    if (i_rx_byte >= TN_WILL && i_rx_byte <= TN_DONT) begin
                        n_verb  = i_rx_byte;
                        n_state = ST_NEGO;
                    end else if (i_rx_byte == TN_SB) begin
                        n_state = ST_SBOPT;
                    end else begin
                        if (i_rx_byte == TN_NOP) begin
                            o_act_valid  = 1'b1;
                            o_action.act = ACT_NOP;
                        end
                        n_state = ST_DATA;
                    end
                end
                ST_NEGO: begin
                    if (r_verb == TN_DONT) begin
                        o_act_valid  = 1'b1;
                        o_action.act = ACT_DONT;
                    end else if (r_verb == TN_DO && i_rx_byte == OPT_ECHO) begin
                        o_act_valid  = 1'b1;
                        o_action.act = ACT_ECHO;
                    end
                    n_state = ST_DATA;
                end
                ST_SBOPT: begin
                    n_win   = (i_rx_byte == OPT_WINDOW);
                    n_count = 3'd0;
                    n_bytes = 32'd0;
                    n_state = ST_SBFIRST;
                end
                ST_SBFIRST: begin
                    // first data byte is data even if it is iac
                    n_count = kept_count;
                    n_bytes = kept_bytes;
                    n_state = ST_SBDATA;
                end
                ST_SBDATA: begin
                    if (i_rx_byte == TN_IAC) begin
                        n_state = ST_SBEND;
                    end else begin
                        n_count = kept_count;
                        n_bytes = kept_bytes;
                    end
                end
                ST_SBEND: begin
                    if (r_win && r_count >= NEED_BYTES) begin
                        o_act_valid     = 1'b1;
                        o_action.act    = ACT_WSIZE;
                        o_action.width  = r_bytes[31:16];
                        o_action.height = r_bytes[15:0];
                    end
                    n_state = ST_DATA;
                end
                default: begin
                    if (i_rx_byte == TN_IAC) begin
                        n_state = ST_CMD;
                    end else begin
                        o_act_valid  = 1'b1;
                        o_action.act = ACT_DATA;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_DATA;
            r_verb  <= 8'd0;
            r_win   <= 1'b0;
            r_count <= 3'd0;
        end else begin
            r_state <= n_state;
            r_verb  <= n_verb;
            r_win   <= n_win;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

endmodule

/* hw/rtl/tnp_queue.sv */
// small register queue of parsed actions between parser and expander
`timescale 1ns / 1ps
module tnp_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tnp_pkg::t_action i_action,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output tnp_pkg::t_action o_head
);
    import tnp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_action            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_action;
        end
    end

endmodule

/* hw/rtl/tnp_back.sv */
// result expander: turns the oldest queued action into one to three results
`timescale 1ns / 1ps
module tnp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  tnp_pkg::t_action i_head,
    input  logic             i_pop,
    output logic             o_deq,
    output logic             o_empty,
    output logic [1:0]       o_event_kind,
    output logic [7:0]       o_byte_value,
    output logic [15:0]      o_window_width,
    output logic [15:0]      o_window_height,
    output logic             o_last
);
    import tnp_pkg::*;

    // index of the result within the current action
    logic [1:0] r_sub, n_sub;

    always_comb begin
        o_event_kind    = EV_DATA;
        o_byte_value    = 8'd0;
        o_window_width  = 16'd0;
        o_window_height = 16'd0;
        o_last          = 1'b1;
        unique case (i_head.act)
            ACT_DATA: begin
                o_byte_value = i_head.value;
            end
            ACT_NOP: begin
                o_event_kind = EV_TX;
                o_byte_value = (r_sub == 2'd0) ? TN_IAC : TN_NOP;
                o_last       = (r_sub == 2'd1);
            end
            ACT_DONT: begin
                // reply iac wont <option>
                o_event_kind = EV_TX;
                case (r_sub)
                    2'd0:    o_byte_value = TN_IAC;
                    2'd1:    o_byte_value = TN_WONT;
                    default: o_byte_value = i_head.value;
                endcase
                o_last = (r_sub == 2'd2);
            end
            ACT_ECHO: begin
                o_event_kind = EV_ECHO;
            end
            ACT_WSIZE: begin
                o_event_kind    = EV_WSIZE;
                o_window_width  = i_head.width;
                o_window_height = i_head.height;
            end
            default: begin
                o_event_kind = EV_DATA;
            end
        endcase
    end

    assign o_empty = !i_head_valid;
    assign o_deq   = i_head_valid && i_pop && o_last;

    always_comb begin
        n_sub = r_sub;
        if (i_head_valid && i_pop) begin
            n_sub = o_last ? 2'd0 : r_sub + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 2'd0;
        end else begin
            r_sub <= n_sub;
        end
    end

endmodule
